[rtl/rhp_pkg.sv]
// Shared types, constants and register codes for the rotated halftone pixel block.
package rhp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COORD_MAX      = 16;

   // Width of the cell coordinate before the bias; the biased coordinate is T_BITS wide.
   localparam int CELL_BITS = 20;
   localparam int T_BITS    = CELL_BITS + 8;

   // Reciprocal of 255 for a product below 2^29, shift 37 (taken as 32 after a <<5).
   localparam logic [29:0] RECIP_255 = 30'd538976289;

   localparam logic [2:0] CSR_CELL_PERIOD   = 3'd0;
   localparam logic [2:0] CSR_COS_ANGLE     = 3'd1;
   localparam logic [2:0] CSR_SIN_ANGLE     = 3'd2;
   localparam logic [2:0] CSR_WHITE_DOTS    = 3'd3;
   localparam logic [2:0] CSR_BLEND_WEIGHT  = 3'd4;
   localparam logic [2:0] CSR_JITTER_AMOUNT = 3'd5;
   localparam logic [2:0] CSR_DOT_SHAPE     = 3'd6;

   localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
   localparam logic [1:0] SHAPE_LINE    = 2'd1;
   localparam logic [1:0] SHAPE_DIAMOND = 2'd2;

   // Effective configuration: zero period already mapped to 8, weights saturated.
   typedef struct packed {
      logic [7:0]         period;
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic               white_dots;
      logic [8:0]         blend_weight;
      logic [8:0]         jitter_amount;
      logic [1:0]         dot_shape;
   } rhp_cfg_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [13:0]        lx;
      logic [13:0]        ly;
      logic [T_BITS-1:0]  tx;
      logic [T_BITS-1:0]  ty;
      logic [7:0]         remx;
      logic [7:0]         remy;
      logic signed [21:0] offx;
      logic signed [21:0] offy;
      logic [20:0]        rad;
   } rhp_beat_type;

endpackage

[rtl/rhp_front.sv]
// Front stages: luma, rotation, jitter and radius, then bias of the cell coordinate.
module rhp_front #(
   parameter int COORD_BITS = rhp_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  rhp_pkg::rhp_cfg_type        cfg,
   input  logic                        valid_in,
   input  logic [COORD_BITS-1:0]       pixel_x,
   input  logic [COORD_BITS-1:0]       pixel_y,
   input  logic [7:0]                  red_in,
   input  logic [7:0]                  green_in,
   input  logic [7:0]                  blue_in,
   input  logic [15:0]                 rand_offset_x,
   input  logic [15:0]                 rand_offset_y,
   output logic                        valid_out,
   output rhp_pkg::rhp_beat_type       beat_out
);
   import rhp_pkg::*;

   localparam int PAD = 17 - COORD_BITS;

   logic signed [16:0] xs_w, ys_w, jx_w, jy_w;
   logic [15:0]        lum_w;

   // stage A
   logic               a_valid_ff;
   logic signed [32:0] a_xc_ff, a_ys_ff, a_yc_ff, a_xs_ff;
   logic signed [32:0] a_xc_in, a_ys_in, a_yc_in, a_xs_in;
   logic signed [26:0] a_jxj_ff, a_jyj_ff, a_jxj_in, a_jyj_in;
   logic [23:0]        a_lump_ff, a_lump_in;
   logic [7:0]         a_r_ff, a_g_ff, a_b_ff;

   // stage B
   logic               b_valid_ff;
   logic signed [33:0] b_xr_ff, b_yr_ff, b_xr_in, b_yr_in;
   logic signed [35:0] b_ox_w, b_oy_w;
   logic [53:0]        b_rp_w;
   logic signed [21:0] b_offx_ff, b_offy_ff;
   logic [20:0]        b_rad_ff;
   logic [7:0]         b_r_ff, b_g_ff, b_b_ff;

   // stage C
   logic               c_valid_ff;
   rhp_beat_type       c_beat_ff, c_beat_in;
   logic [T_BITS-1:0]  bias_w;

   assign xs_w  = $signed({{PAD{1'b0}}, pixel_x});
   assign ys_w  = $signed({{PAD{1'b0}}, pixel_y});
   assign jx_w  = $signed({1'b0, rand_offset_x}) - 17'sd32768;
   assign jy_w  = $signed({1'b0, rand_offset_y}) - 17'sd32768;
   assign lum_w = 16'(red_in * 8'd77) + 16'(green_in * 8'd150) + 16'(blue_in * 8'd29);

   assign a_xc_in  = xs_w * cfg.cos_angle;
   assign a_ys_in  = ys_w * cfg.sin_angle;
   assign a_yc_in  = ys_w * cfg.cos_angle;
   assign a_xs_in  = xs_w * cfg.sin_angle;
   assign a_jxj_in = jx_w * $signed({1'b0, cfg.jitter_amount});
   assign a_jyj_in = jy_w * $signed({1'b0, cfg.jitter_amount});
   assign a_lump_in = 24'(lum_w * cfg.period);

   assign b_xr_in = 34'(a_xc_ff) + 34'(a_ys_ff);
   assign b_yr_in = 34'(a_yc_ff) - 34'(a_xs_ff);
   assign b_ox_w  = a_jxj_ff * $signed({1'b0, cfg.period});
   assign b_oy_w  = a_jyj_ff * $signed({1'b0, cfg.period});
   assign b_rp_w  = a_lump_ff * RECIP_255;

   assign bias_w = T_BITS'({cfg.period, {CELL_BITS{1'b0}}});

   always_comb begin
      c_beat_in       = '0;
      c_beat_in.red   = b_r_ff;
      c_beat_in.green = b_g_ff;
      c_beat_in.blue  = b_b_ff;
      c_beat_in.lx    = b_xr_ff[13:0];
      c_beat_in.ly    = b_yr_ff[13:0];
      c_beat_in.tx    = T_BITS'($signed(b_xr_ff[33:14])) + bias_w;
      c_beat_in.ty    = T_BITS'($signed(b_yr_ff[33:14])) + bias_w;
      c_beat_in.offx  = b_offx_ff;
      c_beat_in.offy  = b_offy_ff;
      c_beat_in.rad   = b_rad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_xc_ff   <= a_xc_in;
         a_ys_ff   <= a_ys_in;
         a_yc_ff   <= a_yc_in;
         a_xs_ff   <= a_xs_in;
         a_jxj_ff  <= a_jxj_in;
         a_jyj_ff  <= a_jyj_in;
         a_lump_ff <= a_lump_in;
         a_r_ff    <= red_in;
         a_g_ff    <= green_in;
         a_b_ff    <= blue_in;
         b_xr_ff   <= b_xr_in;
         b_yr_ff   <= b_yr_in;
         b_offx_ff <= b_ox_w[31:10];
         b_offy_ff <= b_oy_w[31:10];
         b_rad_ff  <= b_rp_w[52:32];
         b_r_ff    <= a_r_ff;
         b_g_ff    <= a_g_ff;
         b_b_ff    <= a_b_ff;
         c_beat_ff <= c_beat_in;
      end
   end

   assign valid_out = c_valid_ff;
   assign beat_out  = c_beat_ff;

endmodule

[rtl/rhp_mod_stage.sv]
// One restoring remainder step on both cell coordinates.
module rhp_mod_stage #(
   parameter int BIT_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [7:0]            period,
   input  logic                  valid_in,
   input  rhp_pkg::rhp_beat_type beat_in,
   output logic                  valid_out,
   output rhp_pkg::rhp_beat_type beat_out
);
   import rhp_pkg::*;

   logic         valid_ff;
   rhp_beat_type beat_ff, beat_in_w;
   logic [8:0]   tmpx, tmpy, difx, dify;

   assign tmpx = {beat_in.remx, beat_in.tx[BIT_IDX]};
   assign tmpy = {beat_in.remy, beat_in.ty[BIT_IDX]};
   assign difx = tmpx - {1'b0, period};
   assign dify = tmpy - {1'b0, period};

   always_comb begin
      beat_in_w      = beat_in;
      beat_in_w.remx = (tmpx >= {1'b0, period}) ? difx[7:0] : tmpx[7:0];
      beat_in_w.remy = (tmpy >= {1'b0, period}) ? dify[7:0] : tmpy[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         beat_ff <= beat_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign beat_out  = beat_ff;

endmodule

[rtl/rhp_back.sv]
// Back stages: offset from centre, shape test and blend into the output register.
module rhp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rhp_pkg::rhp_cfg_type  cfg,
   input  logic                  valid_in,
   input  rhp_pkg::rhp_beat_type beat_in,
   output logic                  valid_out,
   output logic [7:0]            red_out,
   output logic [7:0]            green_out,
   output logic [7:0]            blue_out,
   output logic                  in_dot
);
   import rhp_pkg::*;

   // stage D
   logic               d_valid_ff;
   logic signed [24:0] d_dx_ff, d_dy_ff, d_dx_in, d_dy_in;
   logic [20:0]        d_rad_ff;
   logic [7:0]         d_r_ff, d_g_ff, d_b_ff;
   logic signed [24:0] ctr_w;

   // stage E
   logic               e_valid_ff;
   logic [23:0]        adx_w, ady_w;
   logic [47:0]        e_sqx_ff, e_sqy_ff;
   logic [41:0]        e_sqr_ff;
   logic [24:0]        e_sum_ff, e_dy2_ff;
   logic [20:0]        e_rad_ff;
   logic [7:0]         e_r_ff, e_g_ff, e_b_ff;

   // stage F
   logic               f_valid_ff;
   logic               f_in_ff, f_in_in;
   logic [7:0]         f_r_ff, f_g_ff, f_b_ff;
   logic [47:0]        dist_w;

   // stage G
   logic               g_valid_ff;
   logic [7:0]         g_r_ff, g_g_ff, g_b_ff;
   logic               g_in_ff;
   logic [7:0]         col_w;
   logic [8:0]         inv_w;
   logic [16:0]        mr_w, mg_w, mb_w;

   assign ctr_w   = $signed({4'd0, cfg.period, 13'd0}) ;
   assign d_dx_in = $signed({3'd0, beat_in.remx, beat_in.lx}) - ctr_w - 25'(beat_in.offx);
   assign d_dy_in = $signed({3'd0, beat_in.remy, beat_in.ly}) - ctr_w - 25'(beat_in.offy);

   assign adx_w = d_dx_ff[24] ? 24'(-d_dx_ff) : d_dx_ff[23:0];
   assign ady_w = d_dy_ff[24] ? 24'(-d_dy_ff) : d_dy_ff[23:0];

   assign dist_w = e_sqx_ff + e_sqy_ff;

   always_comb begin
      case (cfg.dot_shape)
         SHAPE_LINE:    f_in_in = e_dy2_ff < {4'd0, e_rad_ff};
         SHAPE_DIAMOND: f_in_in = e_sum_ff < {4'd0, e_rad_ff};
         default:       f_in_in = dist_w < {6'd0, e_sqr_ff};
      endcase
   end

   assign col_w = (f_in_ff ^ cfg.white_dots) ? 8'd0 : 8'd255;
   assign inv_w = 9'd256 - cfg.blend_weight;
   assign mr_w  = 17'(f_r_ff * inv_w) + 17'(col_w * cfg.blend_weight);
   assign mg_w  = 17'(f_g_ff * inv_w) + 17'(col_w * cfg.blend_weight);
   assign mb_w  = 17'(f_b_ff * inv_w) + 17'(col_w * cfg.blend_weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= valid_in;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_dx_ff  <= d_dx_in;
         d_dy_ff  <= d_dy_in;
         d_rad_ff <= beat_in.rad;
         d_r_ff   <= beat_in.red;
         d_g_ff   <= beat_in.green;
         d_b_ff   <= beat_in.blue;
         e_sqx_ff <= adx_w * adx_w;
         e_sqy_ff <= ady_w * ady_w;
         e_sqr_ff <= d_rad_ff * d_rad_ff;
         e_sum_ff <= {1'b0, adx_w} + {1'b0, ady_w};
         e_dy2_ff <= {ady_w, 1'b0};
         e_rad_ff <= d_rad_ff;
         e_r_ff   <= d_r_ff;
         e_g_ff   <= d_g_ff;
         e_b_ff   <= d_b_ff;
         f_in_ff  <= f_in_in;
         f_r_ff   <= e_r_ff;
         f_g_ff   <= e_g_ff;
         f_b_ff   <= e_b_ff;
         g_r_ff   <= mr_w[15:8];
         g_g_ff   <= mg_w[15:8];
         g_b_ff   <= mb_w[15:8];
         g_in_ff  <= f_in_ff;
      end
   end

   assign valid_out = g_valid_ff;
   assign red_out   = g_r_ff;
   assign green_out = g_g_ff;
   assign blue_out  = g_b_ff;
   assign in_dot    = g_in_ff;

endmodule

[rtl/rotated_halftone_pixel.sv]
// Top level of the rotated halftone screen pixel pipeline.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  pixel_x/y, red/green/blue_in, rand_offset_x/y
//   rsp      out        rsp_valid/rsp_stall  red/green/blue_out, in_dot
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// One beat per cycle while the output is not stalled; 3 front stages, 28 remainder stages
// (one bit of the biased cell coordinate each), 4 back stages ending in the output register.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; req_stall follows rsp_valid and rsp_stall.
module rotated_halftone_pixel #(
   parameter int COORD_BITS = rhp_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   input  logic [15:0]           req_rand_offset_x,
   input  logic [15:0]           req_rand_offset_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_in_dot,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import rhp_pkg::*;

   rhp_cfg_type  cfg_ff, cfg_in;
   logic         en;
   logic         chain_valid [0:T_BITS];
   rhp_beat_type chain_beat  [0:T_BITS];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CELL_PERIOD:
               cfg_in.period = (csr_wdata[7:0] == 8'd0) ? 8'd8 : csr_wdata[7:0];
            CSR_COS_ANGLE:     cfg_in.cos_angle = $signed(csr_wdata);
            CSR_SIN_ANGLE:     cfg_in.sin_angle = $signed(csr_wdata);
            CSR_WHITE_DOTS:    cfg_in.white_dots = csr_wdata[0];
            CSR_BLEND_WEIGHT:
               cfg_in.blend_weight = (csr_wdata[8:0] > 9'd256) ? 9'd256 : csr_wdata[8:0];
            CSR_JITTER_AMOUNT:
               cfg_in.jitter_amount = (csr_wdata[8:0] > 9'd256) ? 9'd256 : csr_wdata[8:0];
            CSR_DOT_SHAPE:     cfg_in.dot_shape = csr_wdata[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period        <= 8'd8;
         cfg_ff.cos_angle     <= 16'sd16384;
         cfg_ff.sin_angle     <= 16'sd0;
         cfg_ff.white_dots    <= 1'b0;
         cfg_ff.blend_weight  <= 9'd0;
         cfg_ff.jitter_amount <= 9'd0;
         cfg_ff.dot_shape     <= SHAPE_CIRCLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // advance everything unless a finished beat is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   rhp_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .cfg           (cfg_ff),
      .valid_in      (req_valid),
      .pixel_x       (req_pixel_x),
      .pixel_y       (req_pixel_y),
      .red_in        (req_red_in),
      .green_in      (req_green_in),
      .blue_in       (req_blue_in),
      .rand_offset_x (req_rand_offset_x),
      .rand_offset_y (req_rand_offset_y),
      .valid_out     (chain_valid[0]),
      .beat_out      (chain_beat[0])
   );

   for (genvar i = 0; i < T_BITS; i++) begin : g_mod
      rhp_mod_stage #(
         .BIT_IDX(T_BITS - 1 - i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .period    (cfg_ff.period),
         .valid_in  (chain_valid[i]),
         .beat_in   (chain_beat[i]),
         .valid_out (chain_valid[i+1]),
         .beat_out  (chain_beat[i+1])
      );
   end

   rhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .valid_in  (chain_valid[T_BITS]),
      .beat_in   (chain_beat[T_BITS]),
      .valid_out (rsp_valid),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out),
      .in_dot    (rsp_in_dot)
   );

endmodule

[rtl/rhp_checker.sv]
// Port-level checks for the rotated halftone pixel block, bound to the top level.
module rhp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_red_out,
   input logic [7:0]            rsp_green_out,
   input logic [7:0]            rsp_blue_out,
   input logic                  rsp_in_dot
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out)
         && $stable(rsp_blue_out) && $stable(rsp_in_dot))
      else $error("held result beat changed");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output held");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind rotated_halftone_pixel rhp_checker u_rhp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_in_dot    (rsp_in_dot)
);
